>>> rtl/alr_pkg.sv
`timescale 1ns / 1ps
package alr_pkg;
  localparam int SampleBitsDef = 24;
  localparam int PhaseFracBitsDef = 16;
  localparam int CoefBits = 24;
  localparam int CoefFrac = 22;
  localparam int StepBits = 24;
  localparam int CfgIdxBits = 3;

  localparam logic [CfgIdxBits-1:0] RegMode = 3'd0;
  localparam logic [CfgIdxBits-1:0] RegStep = 3'd1;
  localparam logic [CfgIdxBits-1:0] RegS1Gain = 3'd2;
  localparam logic [CfgIdxBits-1:0] RegS1Fb1 = 3'd3;
  localparam logic [CfgIdxBits-1:0] RegS1Fb2 = 3'd4;
  localparam logic [CfgIdxBits-1:0] RegS2Gain = 3'd5;
  localparam logic [CfgIdxBits-1:0] RegS2Fb1 = 3'd6;
  localparam logic [CfgIdxBits-1:0] RegS2Fb2 = 3'd7;

  localparam logic [1:0] ModeBypass = 2'd0;
  localparam logic [1:0] ModeInterp = 2'd1;

  // Operation codes for the shared multiply-accumulate unit.
  typedef enum logic [1:0] {
    MAC_CLEAR = 2'd0,
    MAC_ADD   = 2'd1,
    MAC_SUB   = 2'd2,
    MAC_HOLD  = 2'd3
  } mac_op_t;
endpackage

>>> rtl/alr_if.sv
`timescale 1ns / 1ps
interface alr_sample_if #(
  parameter int SampleBits = 24
) ();
  logic valid;
  logic ready;
  logic signed [SampleBits-1:0] sample;
  logic last;
  modport source (output valid, output sample, output last, input ready);
  modport sink (input valid, input sample, input last, output ready);
endinterface

interface alr_cfg_if ();
  logic valid;
  logic ready;
  logic [2:0] index;
  logic [23:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

>>> rtl/alr_mac.sv
`timescale 1ns / 1ps
module alr_mac
  import alr_pkg::*;
#(
  parameter int AW = 27,
  parameter int BW = 25,
  parameter int AccBits = 60
) (
  input  logic clk,
  input  mac_op_t op,
  input  logic signed [AW-1:0] a,
  input  logic signed [BW-1:0] b,
  output logic signed [AccBits-1:0] acc
);
  logic signed [AW+BW-1:0] prod;

  // One product each cycle, accumulated into a single wide register.
  assign prod = a * b;

  always_ff @(posedge clk) begin
    case (op)
      MAC_CLEAR: acc <= '0;
      MAC_ADD:   acc <= acc + AccBits'(prod);
      MAC_SUB:   acc <= acc - AccBits'(prod);
      default:   acc <= acc;
    endcase
  end
endmodule

>>> rtl/antialias_linear_resampler.sv
`timescale 1ns / 1ps
// Streaming linear-interpolation resampler with an optional two-section
// low-pass ahead of it. All multiplications go through one shared
// multiply-accumulate unit run by a small sequencer. A bypass sample is
// registered straight to the output. In interpolating modes a sample
// first passes the filter states (in modes 2 and 3) and a decide state,
// and each interpolated result then takes a clear, a multiply and an
// output step. Results that repeat the final sample of a stream come from
// the output step alone, after a check state. Every result also waits for
// the consumer to take it. The block takes no new sample and no register
// write until all results of the current sample are taken.
module antialias_linear_resampler
  import alr_pkg::*;
#(
  parameter int SAMPLE_BITS = SampleBitsDef,
  parameter int PHASE_FRAC_BITS = PhaseFracBitsDef
) (
  input logic clk,
  input logic rst,
  alr_cfg_if.sink cfg,
  alr_sample_if.sink in_ch,
  alr_sample_if.source out_ch
);
  localparam int SB = SAMPLE_BITS;
  localparam int PF = PHASE_FRAC_BITS;
  localparam int PhBits = PF + 9;
  localparam int AW = SB + 3;
  localparam int BW = (CoefBits > PF + 1) ? CoefBits + 1 : PF + 2;
  localparam int AccBits = AW + BW + 4;
  localparam logic [PhBits-1:0] PhaseOne = PhBits'(1) << PF;
  localparam logic [PhBits-1:0] PhaseTwo = PhBits'(2) << PF;
  localparam logic [PhBits-1:0] StepMin = PhBits'(1) << (PF - 5);
  localparam logic signed [SB-1:0] SMax = {1'b0, {(SB-1){1'b1}}};
  localparam logic signed [SB-1:0] SMin = {1'b1, {(SB-1){1'b0}}};

  typedef enum logic [3:0] {
    S_IDLE, S_F1A, S_F1B, S_F1C, S_F1D, S_F2A, S_F2B, S_F2C, S_F2D,
    S_DECIDE, S_IA, S_IB, S_OUT, S_TAIL
  } state_t;

  // Configuration registers.
  logic [1:0] mode;
  logic [StepBits-1:0] step_ratio;
  logic signed [CoefBits-1:0] coefs [8];

  // Stream state.
  state_t state;
  logic first_pending;
  logic signed [SB-1:0] prev_filtered, cur, x_in;
  logic [PhBits-1:0] phase_acc;
  logic signed [SB-1:0] s1_in_d1, s1_in_d2, s1_out_d1, s1_out_d2, s2_out_d1, s2_out_d2;
  logic signed [SB-1:0] s1_res;
  logic last_in, tail;
  logic signed [SB-1:0] out_sample;
  logic out_last, out_valid;

  // Shared unit operands.
  mac_op_t op;
  logic signed [AW-1:0] ma;
  logic signed [BW-1:0] mb;
  logic signed [AccBits-1:0] acc;

  alr_mac #(.AW(AW), .BW(BW), .AccBits(AccBits)) u_mac (
    .clk(clk), .op(op), .a(ma), .b(mb), .acc(acc)
  );

  logic [PhBits-1:0] step_eff;
  logic signed [AccBits-1:0] fsum, isum;
  logic signed [SB-1:0] fsat, isat;
  logic signed [AccBits-1:0] iv;
  assign step_eff = (PhBits'(step_ratio) < StepMin) ? StepMin : PhBits'(step_ratio);

  // Rounding and clamping of the accumulator for filter and interpolation.
  always_comb begin
    fsum = (acc + (AccBits'(1) <<< (CoefFrac - 1))) >>> CoefFrac;
    if (fsum > AccBits'(SMax)) fsat = SMax;
    else if (fsum < AccBits'(SMin)) fsat = SMin;
    else fsat = fsum[SB-1:0];
    isum = (acc + (AccBits'(1) <<< (PF - 1))) >>> PF;
    iv = isum + AccBits'(prev_filtered);
    if (iv > AccBits'(SMax)) isat = SMax;
    else if (iv < AccBits'(SMin)) isat = SMin;
    else isat = iv[SB-1:0];
  end

  // Operand selection per sequencer step.
  always_comb begin
    op = MAC_HOLD;
    ma = '0;
    mb = '0;
    case (state)
      S_F1A: begin
        op = MAC_CLEAR;
      end
      S_F1B: begin
        op = MAC_ADD;
        ma = AW'(x_in) + (AW'(s1_in_d1) <<< 1) + AW'(s1_in_d2);
        mb = BW'(coefs[RegS1Gain]);
      end
      S_F1C: begin
        op = MAC_SUB; ma = AW'(s1_out_d1); mb = BW'(coefs[RegS1Fb1]);
      end
      S_F1D: begin
        op = MAC_SUB; ma = AW'(s1_out_d2); mb = BW'(coefs[RegS1Fb2]);
      end
      S_F2A: begin
        op = MAC_CLEAR;
      end
      S_F2B: begin
        op = MAC_ADD;
        ma = AW'(s1_res) + (AW'(s1_out_d1) <<< 1) + AW'(s1_out_d2);
        mb = BW'(coefs[RegS2Gain]);
      end
      S_F2C: begin
        op = MAC_SUB; ma = AW'(s2_out_d1); mb = BW'(coefs[RegS2Fb1]);
      end
      S_F2D: begin
        op = MAC_SUB; ma = AW'(s2_out_d2); mb = BW'(coefs[RegS2Fb2]);
      end
      S_IA: begin
        op = MAC_CLEAR;
      end
      S_IB: begin
        op = MAC_ADD;
        ma = AW'(cur) - AW'(prev_filtered);
        mb = BW'({1'b0, phase_acc[PF:0]});
      end
      default: op = MAC_HOLD;
    endcase
  end

  assign cfg.ready = (state == S_IDLE) && !out_valid;
  assign in_ch.ready = (state == S_IDLE) && !out_valid;
  assign out_ch.valid = out_valid;
  assign out_ch.sample = out_sample;
  assign out_ch.last = out_last;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= ModeBypass;
      step_ratio <= StepBits'(65536);
      for (int i = 0; i < 8; i++) coefs[i] <= '0;
    end else if (cfg.valid && cfg.ready) begin
      if (cfg.index == RegMode) mode <= cfg.data[1:0];
      else if (cfg.index == RegStep) step_ratio <= cfg.data;
      else coefs[cfg.index] <= cfg.data;
    end
  end

  // Sequencer with registered result beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      first_pending <= 1'b1;
      prev_filtered <= '0;
      phase_acc <= '0;
      s1_in_d1 <= '0; s1_in_d2 <= '0; s1_out_d1 <= '0;
      s1_out_d2 <= '0; s2_out_d1 <= '0; s2_out_d2 <= '0;
      tail <= 1'b0;
      last_in <= 1'b0;
    end else begin
      // A taken beat frees the output unless a new one replaces it below.
      if (out_valid && out_ch.ready && state != S_OUT) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_ch.valid && in_ch.ready) begin
            x_in <= in_ch.sample;
            cur <= in_ch.sample;
            last_in <= in_ch.last;
            tail <= 1'b0;
            if (mode == ModeBypass) begin
              out_sample <= in_ch.sample;
              out_last <= in_ch.last;
              out_valid <= 1'b1;
              if (in_ch.last) begin
                first_pending <= 1'b1; prev_filtered <= '0; phase_acc <= '0;
                s1_in_d1 <= '0; s1_in_d2 <= '0; s1_out_d1 <= '0;
                s1_out_d2 <= '0; s2_out_d1 <= '0; s2_out_d2 <= '0;
              end
            end else if (mode == ModeInterp) begin
              state <= S_DECIDE;
            end else begin
              state <= S_F1A;
            end
          end
        end
        S_F1A: state <= S_F1B;
        S_F1B: state <= S_F1C;
        S_F1C: state <= S_F1D;
        S_F1D: state <= S_F2A;
        S_F2A: begin
          s1_res <= fsat;
          state <= S_F2B;
        end
        S_F2B: state <= S_F2C;
        S_F2C: state <= S_F2D;
        S_F2D: begin
          s1_in_d2 <= s1_in_d1; s1_in_d1 <= x_in;
          s1_out_d2 <= s1_out_d1; s1_out_d1 <= s1_res;
          state <= S_DECIDE;
        end
        S_DECIDE: begin
          if (mode[1] && !(mode == ModeInterp)) begin
            s2_out_d2 <= s2_out_d1;
            s2_out_d1 <= fsat;
          end
          // First time here after filtering: latch filtered value.
          if (mode[1]) cur <= fsat;
          if (first_pending) begin
            first_pending <= 1'b0;
            prev_filtered <= mode[1] ? fsat : cur;
            state <= last_in ? S_TAIL : S_IDLE;
            tail <= last_in;
          end else begin
            state <= S_IA;
          end
        end
        S_IA: begin
          if (phase_acc < PhaseOne) begin
            state <= S_IB;
          end else begin
            phase_acc <= phase_acc - PhaseOne;
            prev_filtered <= cur;
            tail <= last_in;
            state <= last_in ? S_TAIL : S_IDLE;
          end
        end
        S_IB: state <= S_OUT;
        S_OUT: begin
          if (!out_valid || out_ch.ready) begin
            out_sample <= tail ? prev_filtered : isat;
            out_valid <= 1'b1;
            phase_acc <= phase_acc + step_eff;
            // On the final sample the last interpolated result closes the
            // stream when no repeated result follows it.
            out_last <= tail ? (phase_acc + step_eff >= PhaseOne)
                             : (last_in && (phase_acc + step_eff >= PhaseTwo));
            if (tail) begin
              if (phase_acc + step_eff >= PhaseOne) begin
                first_pending <= 1'b1; prev_filtered <= '0; phase_acc <= '0;
                s1_in_d1 <= '0; s1_in_d2 <= '0; s1_out_d1 <= '0;
                s1_out_d2 <= '0; s2_out_d1 <= '0; s2_out_d2 <= '0;
                state <= S_IDLE;
              end
            end else begin
              state <= S_IA;
            end
          end
        end
        S_TAIL: begin
          if (phase_acc < PhaseOne) begin
            state <= S_OUT;
          end else begin
            first_pending <= 1'b1; prev_filtered <= '0; phase_acc <= '0;
            s1_in_d1 <= '0; s1_in_d2 <= '0; s1_out_d1 <= '0;
            s1_out_d2 <= '0; s2_out_d1 <= '0; s2_out_d2 <= '0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  // Input is only taken when idle with no pending beat.
  a_in_idle: assert property (@(posedge clk) disable iff (rst)
    in_ch.valid && in_ch.ready |-> state == S_IDLE && !out_valid)
    else $error("input taken while busy");
  // A pending beat holds its data until taken.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ch.ready |=> out_valid && $stable(out_sample))
    else $error("result changed while stalled");
  // The tail never starts with a position already past the end.
  a_tail_phase: assert property (@(posedge clk) disable iff (rst)
    state == S_OUT && tail |-> phase_acc < PhaseOne)
    else $error("tail result beyond end");
`endif
endmodule
